// File: design/two_button_debounce_long_press_keys_defines.svh
// assertion helpers used by the queue design file
`ifndef TWO_BUTTON_DEBOUNCE_LONG_PRESS_KEYS_DEFINES_SVH
`define TWO_BUTTON_DEBOUNCE_LONG_PRESS_KEYS_DEFINES_SVH

// clocked property, ignored while reset is held
`define TBDLPK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant checked on every edge out of reset
`define TBDLPK_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: design/tbdlpk_pkg.sv
package tbdlpk_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = QCNT_W + 2;
    localparam int PUSH_SLOTS  = 4;

    typedef enum logic [2:0] {
        REG_INVERT_LEVEL      = 3'd0,
        REG_SETTLE_TIME       = 3'd1,
        REG_HOLD_LIMIT        = 3'd2,
        REG_PRIMARY_PRESENT   = 3'd3,
        REG_SECONDARY_PRESENT = 3'd4,
        REG_PRIMARY_KEYS      = 3'd5,
        REG_SECONDARY_KEYS    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [7:0] key;
        logic       pressed;
    } evt_t;

    // what one button lane found for the current beat
    typedef struct packed {
        logic       fire;
        logic [7:0] key;
    } lane_res_t;

    typedef struct packed {
        logic valid;
        evt_t evt;
        logic more;
    } pop_t;

endpackage

// File: design/tbdlpk_lane.sv
module tbdlpk_lane
    import tbdlpk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        present,
    input  logic        level,
    input  logic        read_ok,
    input  logic [31:0] now_ms,
    input  logic        invert_level,
    input  logic [15:0] settle_time,
    input  logic [15:0] hold_limit,
    input  logic [15:0] keys,
    output lane_res_t   res
);

    logic        stable_reg;
    logic        stable_next;
    logic [31:0] press_start_reg;
    logic [31:0] press_start_next;
    logic [31:0] last_change_reg;
    logic [31:0] last_change_next;

    logic        raw;
    logic [31:0] elapsed;
    logic [31:0] held;
    logic        change;

    always_comb
    begin
        raw     = level ^ invert_level;
        elapsed = now_ms - last_change_reg;
        held    = now_ms - press_start_reg;
        change  = present && read_ok && (elapsed >= {16'd0, settle_time})
                  && (raw != stable_reg);
    end

    always_comb
    begin
        stable_next      = stable_reg;
        press_start_next = press_start_reg;
        last_change_next = last_change_reg;
        if (accept && change)
        begin
            stable_next      = raw;
            last_change_next = now_ms;
            if (raw)
            begin
                press_start_next = now_ms;
            end
        end
    end

    // a release is the only change that emits key events
    always_comb
    begin
        res.fire = accept && change && !raw;
        res.key  = (held < {16'd0, hold_limit}) ? keys[7:0] : keys[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b0;
            press_start_reg <= 32'd0;
            last_change_reg <= 32'd0;
        end
        else
        begin
            stable_reg      <= stable_next;
            press_start_reg <= press_start_next;
            last_change_reg <= last_change_next;
        end
    end

endmodule

// File: design/tbdlpk_queue.sv
`include "two_button_debounce_long_press_keys_defines.svh"

module tbdlpk_queue
    import tbdlpk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  lane_res_t lane_a,
    input  lane_res_t lane_b,
    output pop_t      pop
);

    evt_t              mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0] head_reg;
    logic [QIDX_W-1:0] head_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    evt_t              slot     [PUSH_SLOTS];
    logic [2:0]        n_push;
    logic              slot_acc [PUSH_SLOTS];
    logic [QIDX_W-1:0] slot_idx [PUSH_SLOTS];
    logic [QSUM_W-1:0] pos      [PUSH_SLOTS];
    logic [QSUM_W-1:0] tsum     [PUSH_SLOTS];
    logic [QSUM_W-1:0] count_push;

    // merge the lanes: primary press/release first, then secondary
    always_comb
    begin
        slot[0] = lane_a.fire ? evt_t'{key: lane_a.key, pressed: 1'b1}
                              : evt_t'{key: lane_b.key, pressed: 1'b1};
        slot[1] = lane_a.fire ? evt_t'{key: lane_a.key, pressed: 1'b0}
                              : evt_t'{key: lane_b.key, pressed: 1'b0};
        slot[2] = evt_t'{key: lane_b.key, pressed: 1'b1};
        slot[3] = evt_t'{key: lane_b.key, pressed: 1'b0};
        n_push  = {1'b0, lane_a.fire, 1'b0} + {1'b0, lane_b.fire, 1'b0};
    end

    // pushes that find the queue full are dropped, so accepted ones form a prefix
    always_comb
    begin
        count_push = QSUM_W'(count_reg);
        for (int k = 0; k < PUSH_SLOTS; k++)
        begin
            pos[k]      = QSUM_W'(count_reg) + QSUM_W'(k);
            slot_acc[k] = (3'(k) < n_push) && (pos[k] < QSUM_W'(QUEUE_DEPTH));
            tsum[k]     = QSUM_W'(head_reg) + pos[k];
            if (tsum[k] >= QSUM_W'(QUEUE_DEPTH))
            begin
                tsum[k] = tsum[k] - QSUM_W'(QUEUE_DEPTH);
            end
            slot_idx[k] = tsum[k][QIDX_W-1:0];
            if (slot_acc[k])
            begin
                count_push = count_push + QSUM_W'(1);
            end
        end
    end

    always_comb
    begin
        pop.valid = count_push != '0;
        pop.more  = count_push > QSUM_W'(1);
        // an empty queue pops straight from the first push of this beat
        if (!pop.valid)
        begin
            pop.evt = '0;
        end
        else if (count_reg == '0)
        begin
            pop.evt = slot[0];
        end
        else
        begin
            pop.evt = mem[head_reg];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (accept)
        begin
            count_next = QCNT_W'(count_push - QSUM_W'(pop.valid));
            if (pop.valid)
            begin
                if (QSUM_W'(head_reg) == QSUM_W'(QUEUE_DEPTH - 1))
                begin
                    head_next = '0;
                end
                else
                begin
                    head_next = head_reg + QIDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PUSH_SLOTS; k++)
        begin
            if (accept && slot_acc[k])
            begin
                mem[slot_idx[k]] <= slot[k];
            end
        end
    end

    `TBDLPK_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
    `TBDLPK_ASSERT(a_hold_idle, !accept |=> $stable(count_reg) && $stable(head_reg), "queue moved without a beat")
    `TBDLPK_ASSERT(a_no_phantom, accept && count_reg == '0 && !lane_a.fire && !lane_b.fire |-> !pop.valid, "pop from empty queue")

endmodule

// File: design/two_button_debounce_long_press_keys.sv
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// poll in  | in_valid / in_ready   | now_ms, primary_/secondary_ level, read_ok
// event out| out_valid / out_ready | event_valid, key_code, key_pressed, more_pending
// config   | cfg_write             | cfg_index, cfg_data
//
// one poll beat per cycle while in_ready is high; its result lands in the output register on the next edge
// both button lanes and the queue update in the same cycle as the input beat
// a held result blocks input only while out_ready is low
// reset (async, low) clears lanes, queue pointers and loads register defaults
module two_button_debounce_long_press_keys
    import tbdlpk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_ms,
    input  logic        primary_level,
    input  logic        primary_read_ok,
    input  logic        secondary_level,
    input  logic        secondary_read_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        event_valid,
    output logic [7:0]  key_code,
    output logic        key_pressed,
    output logic        more_pending
);

    logic        invert_level_reg;
    logic [15:0] settle_time_reg;
    logic [15:0] hold_limit_reg;
    logic        primary_present_reg;
    logic        secondary_present_reg;
    logic [15:0] primary_keys_reg;
    logic [15:0] secondary_keys_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    pop_t        out_pop_reg;

    logic        accept;
    lane_res_t   lane_a;
    lane_res_t   lane_b;
    pop_t        pop;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_level_reg      <= 1'b0;
            settle_time_reg       <= 16'd20;
            hold_limit_reg        <= 16'd500;
            primary_present_reg   <= 1'b1;
            secondary_present_reg <= 1'b0;
            primary_keys_reg      <= 16'h0A09;
            secondary_keys_reg    <= 16'h0B09;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_INVERT_LEVEL:      invert_level_reg      <= cfg_data[0];
                REG_SETTLE_TIME:       settle_time_reg       <= cfg_data;
                REG_HOLD_LIMIT:        hold_limit_reg        <= cfg_data;
                REG_PRIMARY_PRESENT:   primary_present_reg   <= cfg_data[0];
                REG_SECONDARY_PRESENT: secondary_present_reg <= cfg_data[0];
                REG_PRIMARY_KEYS:      primary_keys_reg      <= cfg_data;
                REG_SECONDARY_KEYS:    secondary_keys_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    tbdlpk_lane u_lane_primary (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .present      (primary_present_reg),
        .level        (primary_level),
        .read_ok      (primary_read_ok),
        .now_ms       (now_ms),
        .invert_level (invert_level_reg),
        .settle_time  (settle_time_reg),
        .hold_limit   (hold_limit_reg),
        .keys         (primary_keys_reg),
        .res          (lane_a)
    );

    tbdlpk_lane u_lane_secondary (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .present      (secondary_present_reg),
        .level        (secondary_level),
        .read_ok      (secondary_read_ok),
        .now_ms       (now_ms),
        .invert_level (invert_level_reg),
        .settle_time  (settle_time_reg),
        .hold_limit   (hold_limit_reg),
        .keys         (secondary_keys_reg),
        .res          (lane_b)
    );

    tbdlpk_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .lane_a (lane_a),
        .lane_b (lane_b),
        .pop    (pop)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_pop_reg <= pop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_valid  = out_pop_reg.valid;
    assign key_code     = out_pop_reg.evt.key;
    assign key_pressed  = out_pop_reg.evt.pressed;
    assign more_pending = out_pop_reg.more;

endmodule
